### src/opdf_pkg.sv
// Shared types and constants for the opcode/length packet deframer.
package opdf_pkg;

   // Largest packet including the four header bytes
   localparam int MAX_PACKET = 4096;
   // Payload length cap that follows from the packet size
   localparam logic [16:0] LENGTH_CAP = 17'(MAX_PACKET - 4);

   // Configuration register indexes
   localparam logic CSR_SYNC_VALUE    = 1'b0;
   localparam logic CSR_PAYLOAD_LIMIT = 1'b1;

   // Reset values of the configuration registers
   localparam logic [7:0]  SYNC_VALUE_RESET    = 8'hAA;
   localparam logic [11:0] PAYLOAD_LIMIT_RESET = 12'd4092;

   // Valid opcode range
   localparam logic [7:0] OPCODE_MIN = 8'h01;
   localparam logic [7:0] OPCODE_MAX = 8'h04;

   // One result transaction
   typedef struct packed {
      logic [2:0]  command;
      logic [11:0] payload_length;
      logic [11:0] offset;
      logic [7:0]  payload_byte;
      logic        has_data;
      logic        last;
   } result_type;

endpackage

### src/opcode_length_packet_deframer_core.sv
// A payload byte's result is registered in the output stage before it appears on rsp_.
// Throughput: one byte per cycle when not stalled; parser state and result update together.
// A stalled result sits in a skid stage, so req_tready drops only when both slots are full.
// Reset (synchronous, active high) returns to sync hunting, empties the output stages
// and restores sync_value 0xAA and payload_limit 4092.
// Top level: stream in of received bytes, stream out of payload results.
module opcode_length_packet_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] command, [14:3] payload_length, [26:15] offset, [34:27] payload_byte, [39:35] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] has_data
   output logic        rsp_tlast    // last
);

   logic                 req_accept;
   logic                 result_valid;
   logic                 buf_ready;
   opdf_pkg::result_type result;
   opdf_pkg::result_type out_data;

   assign req_tready = buf_ready;
   assign req_accept = req_tvalid && buf_ready;

   opdf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .byte_valid   (req_accept),
      .rx_byte      (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   opdf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_data   (result),
      .in_ready  (buf_ready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .out_ready (rsp_tready)
   );

   // Pack the result transaction
   assign rsp_tdata = {5'd0, out_data.payload_byte, out_data.offset,
                       out_data.payload_length, out_data.command};
   assign rsp_tuser = out_data.has_data;
   assign rsp_tlast = out_data.last;

endmodule

### src/opdf_parser.sv
// Deframing state machine: header parsing, payload counting and result forming.
module opdf_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [11:0]             csr_wdata,
   input  logic                    byte_valid,
   input  logic [7:0]              rx_byte,
   output logic                    result_valid,
   output opdf_pkg::result_type    result
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_OPCODE  = 2'd1;
   localparam logic [1:0] PH_LENGTH  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   logic [7:0]  sync_value_ff;
   logic [11:0] payload_limit_ff;
   logic [1:0]  phase_ff, phase_in;
   logic        header_count_ff, header_count_in;
   logic [2:0]  opcode_ff, opcode_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [11:0] expected_ff, expected_in;
   logic [11:0] count_ff, count_in;

   logic [15:0] length_full;
   logic [15:0] limit;
   logic [12:0] count_next;
   logic        final_byte;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff    <= opdf_pkg::SYNC_VALUE_RESET;
         payload_limit_ff <= opdf_pkg::PAYLOAD_LIMIT_RESET;
      end else if (csr_we) begin
         if (csr_index == opdf_pkg::CSR_SYNC_VALUE) begin
            sync_value_ff <= csr_wdata[7:0];
         end else begin
            payload_limit_ff <= csr_wdata;
         end
      end
   end

   // Effective limit: the smaller of the register and the packet cap
   assign limit = ({5'd0, payload_limit_ff} < opdf_pkg::LENGTH_CAP)
                  ? {4'd0, payload_limit_ff} : opdf_pkg::LENGTH_CAP[15:0];
   assign length_full = {rx_byte, length_low_ff};
   assign count_next  = {1'b0, count_ff} + 13'd1;
   assign final_byte  = count_next >= {1'b0, expected_ff};

   // Next state and result for the current byte
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      opcode_in       = opcode_ff;
      length_low_in   = length_low_ff;
      expected_in     = expected_ff;
      count_in        = count_ff;
      result_valid    = 1'b0;
      result.command        = opcode_ff;
      result.payload_length = expected_ff;
      result.offset         = count_ff;
      result.payload_byte   = rx_byte;
      result.has_data       = 1'b1;
      result.last           = final_byte;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == sync_value_ff) begin
               phase_in        = PH_OPCODE;
               header_count_in = 1'b0;
               count_in        = 12'd0;
            end
         end
         PH_OPCODE: begin
            header_count_in = 1'b0;
            if (rx_byte >= opdf_pkg::OPCODE_MIN && rx_byte <= opdf_pkg::OPCODE_MAX) begin
               opcode_in = rx_byte[2:0];
               phase_in  = PH_LENGTH;
            end else begin
               phase_in = PH_HUNT;
               count_in = 12'd0;
            end
         end
         PH_LENGTH: begin
            if (!header_count_ff) begin
               length_low_in   = rx_byte;
               header_count_in = 1'b1;
            end else begin
               header_count_in = 1'b0;
               count_in        = 12'd0;
               if (length_full > limit) begin
                  phase_in = PH_HUNT;
               end else begin
                  // limit is below 4096, so the length fits 12 bits
                  expected_in = length_full[11:0];
                  if (length_full == 16'd0) begin
                     // empty packet ends here with a data-less last result
                     result_valid          = 1'b1;
                     result.command        = opcode_ff;
                     result.payload_length = 12'd0;
                     result.offset         = 12'd0;
                     result.payload_byte   = 8'd0;
                     result.has_data       = 1'b0;
                     result.last           = 1'b1;
                     phase_in              = PH_HUNT;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            result_valid = 1'b1;
            if (final_byte) begin
               phase_in        = PH_HUNT;
               header_count_in = 1'b0;
               count_in        = 12'd0;
            end else begin
               count_in = count_next[11:0];
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      if (!byte_valid) begin
         result_valid = 1'b0;
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         header_count_ff <= 1'b0;
         opcode_ff       <= 3'd0;
         length_low_ff   <= 8'd0;
         expected_ff     <= 12'd0;
         count_ff        <= 12'd0;
      end else if (byte_valid) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         opcode_ff       <= opcode_in;
         length_low_ff   <= length_low_in;
         expected_ff     <= expected_in;
         count_ff        <= count_in;
      end
   end

endmodule

### src/opdf_out_buf.sv
// Output register with a skid stage so the input side keeps flowing under stall.
module opdf_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  opdf_pkg::result_type in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output opdf_pkg::result_type out_data,
   input  logic                 out_ready
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   opdf_pkg::result_type main_ff, main_in;
   opdf_pkg::result_type skid_ff, skid_in;
   logic                 main_pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign main_pop  = main_valid_ff && out_ready;

   // Fill main first, spill to skid when main is held
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

### tb/tb_opcode_length_packet_deframer_core.sv
// Self-checking testbench for the opcode/length packet deframer core.
`timescale 1ns / 100ps

module tb_opcode_length_packet_deframer_core;

   typedef enum logic [1:0] {HUNT, GET_OPCODE, GET_LENGTH, GET_PAYLOAD} parse_phase_type;
   typedef enum logic [7:0] {
      OP_ERASE   = 8'h01,
      OP_PROGRAM = 8'h02,
      OP_VERIFY  = 8'h03,
      OP_BOOT    = 8'h04
   } opcode_type;

   // Tracks the parser state and holds the payload results still owed by the block
   class deframe_checker_type;
      logic [7:0]           sync_byte;
      logic [11:0]          limit_reg;
      parse_phase_type      phase;
      bit                   hdr_seen;
      logic [2:0]           cur_op;
      logic [7:0]           len_low;
      logic [12:0]          pkt_len;
      logic [12:0]          rx_count;
      opdf_pkg::result_type pending_results[$];
      int                   errors;

      function new();
         sync_byte = opdf_pkg::SYNC_VALUE_RESET;
         limit_reg = opdf_pkg::PAYLOAD_LIMIT_RESET;
         cur_op    = '0;
         len_low   = '0;
         pkt_len   = '0;
         errors    = 0;
         drop_frame();
      endfunction

      function void drop_frame();
         phase    = HUNT;
         hdr_seen = 1'b0;
         rx_count = '0;
      endfunction

      function void write_reg(logic idx, logic [11:0] value);
         if (idx == opdf_pkg::CSR_SYNC_VALUE) begin
            sync_byte = value[7:0];
         end else begin
            limit_reg = value;
         end
      endfunction

      function void queue_result(logic [11:0] off, logic [7:0] data, logic has, logic fin);
         opdf_pkg::result_type r;
         r.command        = cur_op;
         r.payload_length = pkt_len[11:0];
         r.offset         = off;
         r.payload_byte   = data;
         r.has_data       = has;
         r.last           = fin;
         pending_results.push_back(r);
      endfunction

      // One accepted rx byte: advance the parser, queue any payload result
      function void note_rx_byte(logic [7:0] b);
         logic [15:0] len;
         logic [16:0] lim_eff;
         logic        fin;
         unique case (phase)
            HUNT: begin
               if (b == sync_byte) begin
                  phase    = GET_OPCODE;
                  hdr_seen = 1'b0;
                  rx_count = '0;
               end
            end
            GET_OPCODE: begin
               if (b >= opdf_pkg::OPCODE_MIN && b <= opdf_pkg::OPCODE_MAX) begin
                  cur_op   = b[2:0];
                  hdr_seen = 1'b0;
                  phase    = GET_LENGTH;
               end else begin
                  drop_frame();
               end
            end
            GET_LENGTH: begin
               if (!hdr_seen) begin
                  len_low  = b;
                  hdr_seen = 1'b1;
               end else begin
                  len      = {b, len_low};
                  lim_eff  = ({5'd0, limit_reg} < opdf_pkg::LENGTH_CAP)
                             ? {5'd0, limit_reg} : opdf_pkg::LENGTH_CAP;
                  hdr_seen = 1'b0;
                  if ({1'b0, len} > lim_eff) begin
                     drop_frame();
                  end else begin
                     pkt_len  = len[12:0];
                     rx_count = '0;
                     if (len == 16'd0) begin
                        // empty packet: one data-less closing result
                        queue_result(12'd0, 8'd0, 1'b0, 1'b1);
                        drop_frame();
                     end else begin
                        phase = GET_PAYLOAD;
                     end
                  end
               end
            end
            default: begin
               fin = ({1'b0, rx_count} + 14'd1 >= {1'b0, pkt_len});
               queue_result(rx_count[11:0], b, 1'b1, fin);
               if (fin) begin
                  drop_frame();
               end else begin
                  rx_count = rx_count + 13'd1;
               end
            end
         endcase
      endfunction

      function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // One accepted result transaction against the oldest expectation
      function void check_result(logic [39:0] data, logic has_data, logic last);
         opdf_pkg::result_type e;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                     $time, data, has_data, last);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         compare_field("command", 32'(e.command), 32'(data[2:0]));
         compare_field("payload_length", 32'(e.payload_length), 32'(data[14:3]));
         compare_field("offset", 32'(e.offset), 32'(data[26:15]));
         compare_field("payload_byte", 32'(e.payload_byte), 32'(data[34:27]));
         compare_field("tdata padding", 32'd0, 32'(data[39:35]));
         compare_field("has_data", 32'(e.has_data), 32'(has_data));
         compare_field("last", 32'(e.last), 32'(last));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [11:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   deframe_checker_type sb;
   int                  bytes_sent = 0;
   bit                  calm = 1'b0;

   opcode_length_packet_deframer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   // Drive one rx byte after a random idle gap (possibly none), and hold it until the transaction completes
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [7:0] op, input logic [15:0] len);
      send_byte(sb.sync_byte);
      send_byte(op);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
   endtask

   task automatic send_payload(input int n);
      repeat (n) send_byte(8'($urandom));
   endtask

   task automatic write_csr(input logic idx, input logic [11:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and let every owed result come out before touching registers
   task automatic drain_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One random frame: mostly well formed, some bad opcodes, oversize and truncated ones
   task automatic rand_packet();
      int          kind;
      int          lim_eff;
      int          len;
      logic [7:0]  op;
      lim_eff = (sb.limit_reg < opdf_pkg::LENGTH_CAP) ? int'(sb.limit_reg)
                                                      : int'(opdf_pkg::LENGTH_CAP);
      calm = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(0, 1)) send_byte(8'($urandom));
      kind = $urandom_range(0, 99);
      op   = 8'($urandom_range(opdf_pkg::OPCODE_MIN, opdf_pkg::OPCODE_MAX));
      if (kind < 80) begin
         len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, (lim_eff < 20) ? lim_eff : 20);
         send_header(op, 16'(len));
         send_payload(len);
      end else if (kind < 88) begin
         do op = 8'($urandom); while (op >= opdf_pkg::OPCODE_MIN && op <= opdf_pkg::OPCODE_MAX);
         send_byte(sb.sync_byte);
         send_byte(op);
      end else if (kind < 95) begin
         len = $urandom_range(lim_eff + 1, 65535);
         send_header(op, 16'(len));
      end else begin
         // header promises more bytes than follow; the next frame fills the gap
         len = $urandom_range(1, (lim_eff < 20) ? ((lim_eff < 1) ? 1 : lim_eff) : 20);
         send_header(op, 16'(len));
         send_payload($urandom_range(0, len - 1));
      end
   endtask

   task automatic run_random(input int n);
      int stop_at;
      stop_at = bytes_sent + n;
      while (bytes_sent < stop_at) rand_packet();
   endtask

   // Result side: random stalls, check every accepted transaction
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Main sequence
   initial begin
      sb = new();
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= opdf_pkg::CSR_SYNC_VALUE;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: noise, empty packet, short packet with extreme bytes
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header(OP_ERASE, 16'd0);
      send_header(OP_PROGRAM, 16'd3);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sb.sync_byte);
      // sync byte in opcode slot drops the frame and is not taken as a new sync
      send_byte(sb.sync_byte);
      send_byte(sb.sync_byte);
      send_byte(OP_VERIFY);
      // opcodes just outside the legal range
      send_byte(sb.sync_byte);
      send_byte(opdf_pkg::OPCODE_MIN - 8'd1);
      send_byte(sb.sync_byte);
      send_byte(opdf_pkg::OPCODE_MAX + 8'd1);
      // oversize lengths, one with the sync value as its high byte
      send_header(OP_BOOT, {sb.sync_byte, sb.sync_byte});
      send_header(OP_VERIFY, 16'(opdf_pkg::LENGTH_CAP + 17'd1));
      send_header(OP_BOOT, 16'hFFFF);
      send_header(OP_BOOT, 16'd1);
      send_byte(8'h5A);

      drain_idle();
      run_random(450);

      // Smallest settings: only empty packets get through
      drain_idle();
      write_csr(opdf_pkg::CSR_SYNC_VALUE, 12'h000);
      write_csr(opdf_pkg::CSR_PAYLOAD_LIMIT, 12'd0);
      run_random(250);

      // Limit register above the cap: lengths just over the cap are still dropped
      drain_idle();
      write_csr(opdf_pkg::CSR_SYNC_VALUE, 12'h0FF);
      write_csr(opdf_pkg::CSR_PAYLOAD_LIMIT, 12'hFFF);
      send_header(OP_PROGRAM, 16'(opdf_pkg::LENGTH_CAP + 17'd1));
      send_header(OP_ERASE, 16'h0FFF);
      send_header(OP_VERIFY, 16'd2);
      send_payload(2);
      run_random(300);

      drain_idle();
      write_csr(opdf_pkg::CSR_SYNC_VALUE, 12'($urandom_range(0, 255)));
      write_csr(opdf_pkg::CSR_PAYLOAD_LIMIT, 12'($urandom_range(1, 40)));
      run_random(350);

      drain_idle();
      write_csr(opdf_pkg::CSR_SYNC_VALUE, {4'd0, opdf_pkg::SYNC_VALUE_RESET});
      write_csr(opdf_pkg::CSR_PAYLOAD_LIMIT, opdf_pkg::PAYLOAD_LIMIT_RESET);
      run_random(350);

      drain_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
